// File: hdl/prrq_pkg.sv
// ----------------------------------------------------------------------------
// prrq_pkg
// Shared types and constants of the priority round-robin ready queue.
// ----------------------------------------------------------------------------
package prrq_pkg;

  localparam int NUM_TASKS_DEF  = 16;
  localparam int NUM_LEVELS_DEF = 4;

  localparam int CMD_W  = 2;
  localparam int TASK_W = 4;
  localparam int PRI_W  = 2;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_SELECT  = 2'd1,
    CMD_REMOVE  = 2'd2
  } cmd_e_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_SCAN,
    S_SHIFT,
    S_TAIL,
    S_RESP
  } state_t;

  // One result transaction.
  typedef struct packed {
    status_t             status;
    logic                found;
    logic [TASK_W-1:0]   chosen_task;
  } resp_t;

  // Count update request from the sequencer to the count registers.
  typedef struct packed {
    logic inc;
    logic dec;
  } cnt_upd_t;

endpackage

// File: hdl/prrq_mem.sv
// ----------------------------------------------------------------------------
// prrq_mem
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module prrq_mem #(
  parameter  int DEPTH = prrq_pkg::NUM_TASKS_DEF * prrq_pkg::NUM_LEVELS_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [prrq_pkg::TASK_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [prrq_pkg::TASK_W-1:0] rdata
);
  import prrq_pkg::*;

  logic [TASK_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/prrq_cnt.sv
// ----------------------------------------------------------------------------
// prrq_cnt
// Per-level fill counts with occupancy flags for the level search.
// ----------------------------------------------------------------------------
module prrq_cnt #(
  parameter  int NUM_TASKS  = prrq_pkg::NUM_TASKS_DEF,
  parameter  int NUM_LEVELS = prrq_pkg::NUM_LEVELS_DEF,
  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1,
  localparam int CW = $clog2(NUM_TASKS + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [LW-1:0]            cnt_lvl,
  input  prrq_pkg::cnt_upd_t       cnt_upd,
  output logic [CW-1:0]            cnt_sel,
  output logic [NUM_LEVELS-1:0]    nonempty
);
  import prrq_pkg::*;

  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  logic [CW-1:0] cnt_r [NUM_LEVELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        cnt_r[l] <= '0;
      end
    end else if (cnt_upd.inc) begin
      cnt_r[cnt_lvl] <= cnt_r[cnt_lvl] + CNT_ONE;
    end else if (cnt_upd.dec) begin
      cnt_r[cnt_lvl] <= cnt_r[cnt_lvl] - CNT_ONE;
    end
  end

  assign cnt_sel = cnt_r[cnt_lvl];

  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      nonempty[l] = (cnt_r[l] != '0);
    end
  end

endmodule

// File: hdl/prrq_ctrl.sv
// ----------------------------------------------------------------------------
// prrq_ctrl
// Command sequencer: enqueue, select-and-rotate and remove over the slot
// memory, one slot read and one slot write per cycle.
// ----------------------------------------------------------------------------
module prrq_ctrl #(
  parameter  int NUM_TASKS  = prrq_pkg::NUM_TASKS_DEF,
  parameter  int NUM_LEVELS = prrq_pkg::NUM_LEVELS_DEF,
  localparam int LW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1,
  localparam int CW    = $clog2(NUM_TASKS + 1),
  localparam int DEPTH = NUM_TASKS * NUM_LEVELS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  prrq_pkg::cmd_e_t            in_cmd,
  input  logic [prrq_pkg::TASK_W-1:0] in_tid,
  input  logic [prrq_pkg::PRI_W-1:0]  in_pri,
  output logic                        resp_valid,
  input  logic                        resp_ready,
  output prrq_pkg::resp_t             resp,
  output logic [LW-1:0]               cnt_lvl,
  output prrq_pkg::cnt_upd_t          cnt_upd,
  input  logic [CW-1:0]               cnt_sel,
  input  logic [NUM_LEVELS-1:0]       nonempty,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [prrq_pkg::TASK_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  logic [prrq_pkg::TASK_W-1:0] mem_rdata
);
  import prrq_pkg::*;

  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [CW-1:0] CNT_FULL = CW'(NUM_TASKS);
  localparam logic [LW-1:0] LVL_TOP  = LW'(NUM_LEVELS - 1);

  state_t            state_r,    state_nxt;
  cmd_e_t            cmd_r,      cmd_nxt;
  logic [TASK_W-1:0] tid_r,      tid_nxt;
  logic [LW-1:0]     lvl_r,      lvl_nxt;
  logic [CW-1:0]     idx_r,      idx_nxt;
  logic              pend_r,     pend_nxt;
  logic [CW-1:0]     pend_idx_r, pend_idx_nxt;
  logic [TASK_W-1:0] head_r,     head_nxt;
  resp_t             resp_r,     resp_nxt;

  logic [LW-1:0]     top_lvl;
  logic              any_ne;
  logic [LW-1:0]     enq_lvl;
  logic [AW-1:0]     base;

  // Highest non-empty level.
  always_comb begin
    top_lvl = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (nonempty[l]) begin
        top_lvl = LW'(l);
      end
    end
  end

  assign any_ne  = |nonempty;
  assign enq_lvl = (int'(in_pri) >= NUM_LEVELS) ? LVL_TOP : LW'(in_pri);
  assign base    = AW'(AW'(lvl_r) * AW'(NUM_TASKS));
  assign cnt_lvl = lvl_r;
  assign resp    = resp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    tid_r      <= tid_nxt;
    lvl_r      <= lvl_nxt;
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    head_r     <= head_nxt;
    resp_r     <= resp_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    tid_nxt      = tid_r;
    lvl_nxt      = lvl_r;
    idx_nxt      = idx_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    head_nxt     = head_r;
    resp_nxt     = resp_r;
    in_ready     = 1'b0;
    resp_valid   = 1'b0;
    cnt_upd      = '0;
    mem_we       = 1'b0;
    mem_waddr    = base + AW'(idx_r);
    mem_wdata    = tid_r;
    mem_re       = 1'b0;
    mem_raddr    = base + AW'(idx_r);

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt  = in_cmd;
          tid_nxt  = in_tid;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          case (in_cmd)
            CMD_ENQUEUE: begin
              lvl_nxt   = enq_lvl;
              state_nxt = S_ENQ;
            end
            CMD_SELECT: begin
              lvl_nxt = top_lvl;
              if (any_ne) begin
                state_nxt = S_SHIFT;
              end else begin
                resp_nxt  = '{status: ST_NONE, found: 1'b0, chosen_task: '0};
                state_nxt = S_RESP;
              end
            end
            CMD_REMOVE: begin
              lvl_nxt   = LVL_TOP;
              state_nxt = S_SCAN;
            end
            default: begin
              resp_nxt  = '{status: ST_OK, found: 1'b0, chosen_task: '0};
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_ENQ: begin
        if (cnt_sel == CNT_FULL) begin
          resp_nxt = '{status: ST_FULL, found: 1'b0, chosen_task: '0};
        end else begin
          mem_we      = 1'b1;
          mem_waddr   = base + AW'(cnt_sel);
          mem_wdata   = tid_r;
          cnt_upd.inc = 1'b1;
          resp_nxt    = '{status: ST_OK, found: 1'b0, chosen_task: '0};
        end
        state_nxt = S_RESP;
      end

      // Walk the levels top down, head to tail; compare each slot in the cycle
      // after its read is issued.
      S_SCAN: begin
        priority if (pend_r && mem_rdata == tid_r) begin
          pend_nxt  = 1'b0;
          idx_nxt   = pend_idx_r + CNT_ONE;
          state_nxt = S_SHIFT;
        end else if (idx_r < cnt_sel) begin
          mem_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r;
          idx_nxt      = idx_r + CNT_ONE;
        end else begin
          pend_nxt = 1'b0;
          if (lvl_r == '0) begin
            resp_nxt  = '{status: ST_NONE, found: 1'b0, chosen_task: '0};
            state_nxt = S_RESP;
          end else begin
            lvl_nxt = lvl_r - LW'(1);
            idx_nxt = '0;
          end
        end
      end

      // Move each slot from idx onward down by one index, toward the head. Slot 0
      // read by select is the head: hold it for the tail write.
      S_SHIFT: begin
        if (pend_r) begin
          if (pend_idx_r == '0) begin
            head_nxt = mem_rdata;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = base + AW'(pend_idx_r - CNT_ONE);
            mem_wdata = mem_rdata;
          end
        end
        if (idx_r < cnt_sel) begin
          mem_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r;
          idx_nxt      = idx_r + CNT_ONE;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (cmd_r == CMD_SELECT) begin
              state_nxt = S_TAIL;
            end else begin
              cnt_upd.dec = 1'b1;
              resp_nxt    = '{status: ST_OK, found: 1'b1, chosen_task: tid_r};
              state_nxt   = S_RESP;
            end
          end
        end
      end

      S_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = base + AW'(cnt_sel - CNT_ONE);
        mem_wdata = head_r;
        resp_nxt  = '{status: ST_OK, found: 1'b1, chosen_task: head_r};
        state_nxt = S_RESP;
      end

      S_RESP: begin
        resp_valid = 1'b1;
        if (resp_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("slot read and write hit the same entry");

  a_resp_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (resp_valid && resp.found) |-> (resp.status == ST_OK))
    else $error("found result with non-ok status");

  a_resp_zero_task: assert property (@(posedge clk) disable iff (!rst_n)
    (resp_valid && !resp.found) |-> (resp.chosen_task == '0))
    else $error("task reported without a hit");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction taken while busy");

  a_cnt_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_upd.inc |-> cnt_sel < CNT_FULL) and (cnt_upd.dec |-> cnt_sel != '0))
    else $error("level count over- or underflow");

endmodule

// File: hdl/priority_round_robin_ready_queue_top.sv
// ----------------------------------------------------------------------------
// priority_round_robin_ready_queue_top
// Multilevel priority round-robin ready queue with slot memory and
// registered result output.
// ----------------------------------------------------------------------------
//  channel | dir | ports                          | payload
//  --------+-----+--------------------------------+------------------------------
//  in      | in  | in_tvalid in_tready in_tdata   | command, task_id, priority_req
//  out     | out | out_tvalid out_tready out_tdata| chosen_task, found, status
//
//  Select and remove walk the slot memory one slot per cycle: select
//  rotates the highest non-empty level, remove scans the levels top down
//  and closes the gap behind the hit; enqueue writes at most one slot.
//  One command is in work at a time; the next is taken once its result sits
//  in the output register, even while out_tready is low.
//  Synchronous active-low reset empties all levels; slot contents are not
//  cleared, the fill counts guard them.
// ----------------------------------------------------------------------------
module priority_round_robin_ready_queue_top #(
  parameter int NUM_TASKS  = prrq_pkg::NUM_TASKS_DEF,
  parameter int NUM_LEVELS = prrq_pkg::NUM_LEVELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // command[1:0], task_id[5:2], priority_req[7:6]
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // chosen_task[3:0], found[4], status[6:5], zero[7]
);
  import prrq_pkg::*;

  localparam int LW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int CW    = $clog2(NUM_TASKS + 1);
  localparam int DEPTH = NUM_TASKS * NUM_LEVELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                  resp_valid;
  logic                  resp_ready;
  resp_t                 resp;
  logic [LW-1:0]         cnt_lvl;
  cnt_upd_t              cnt_upd;
  logic [CW-1:0]         cnt_sel;
  logic [NUM_LEVELS-1:0] nonempty;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [TASK_W-1:0]     mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [TASK_W-1:0]     mem_rdata;

  logic                  out_valid_r;
  logic [7:0]            out_data_r;

  prrq_ctrl #(
    .NUM_TASKS  (NUM_TASKS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (cmd_e_t'(in_tdata[1:0])),
    .in_tid     (in_tdata[5:2]),
    .in_pri     (in_tdata[7:6]),
    .resp_valid (resp_valid),
    .resp_ready (resp_ready),
    .resp       (resp),
    .cnt_lvl    (cnt_lvl),
    .cnt_upd    (cnt_upd),
    .cnt_sel    (cnt_sel),
    .nonempty   (nonempty),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  prrq_cnt #(
    .NUM_TASKS  (NUM_TASKS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_cnt (
    .clk      (clk),
    .rst_n    (rst_n),
    .cnt_lvl  (cnt_lvl),
    .cnt_upd  (cnt_upd),
    .cnt_sel  (cnt_sel),
    .nonempty (nonempty)
  );

  prrq_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: take a new result when empty or being drained.
  assign resp_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_valid && resp_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_valid && resp_ready) begin
      out_data_r <= {1'b0, resp.status, resp.found, resp.chosen_task};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
